/* rtl/bcm_pkg.sv */
// Shared constants and types for the block cache.
package bcm_pkg;
  localparam int MAX_ENTRIES = 64;
  localparam int BLOCK_WORDS = 32;
  localparam int SLOT_W = $clog2(MAX_ENTRIES);
  localparam int WORD_W = $clog2(BLOCK_WORDS);
  localparam int DATA_AW = SLOT_W + WORD_W;
  localparam int CNT_W = $clog2(BLOCK_WORDS + 1);
  localparam int NUM_W = $clog2(MAX_ENTRIES + 1);

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_UPDATE = 2'd1;
  localparam logic [1:0] CMD_INSERT = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_OFF = 2'd2;

  localparam logic [1:0] REG_ENABLED = 2'd0;
  localparam logic [1:0] REG_ENTRIES = 2'd1;

  typedef struct packed {
    logic [1:0] status;
    logic [63:0] word;
    logic last;
  } result_t;
endpackage

/* rtl/bcm_ram.sv */
// Generic single-port-write, single-read RAM with registered read.
module bcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* rtl/block_cache_mru_replace.sv */
// Top level of the fully associative block cache with MRU replacement.
// A new beat can follow each accepted beat directly, except after a lookup hit,
// which streams the 32 block words out of the data RAM one per cycle while the
// receiver does not stall, set by the single read port of the data RAM: the
// stream is started, the 32 words are read, and the last word lands in the
// output register before the next beat is taken.
// Tags, valid bits and stamps sit in flip-flops and are compared across all
// active entries in parallel; the MRU entry is picked by a pairwise compare tree.
// Block data sits in a 2048 x 64 RAM with registered read. Results leave
// through a one-entry output register; a new beat is taken only when that
// register is empty or is being read in the same cycle. Data words never
// written read back undefined.
module block_cache_mru_replace
  import bcm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: command[1:0], disk_id[5:2], block_id[13:6], data_word[77:14], pad
  input  logic [79:0] in_tdata,
  // tlast: last_word
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: status[1:0], read_word[65:2], pad
  output logic [71:0] out_tdata,
  // tlast: last_result
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  logic [1:0]  cmd;
  logic [3:0]  disk;
  logic [7:0]  blk;
  logic [63:0] word;
  assign cmd  = in_tdata[1:0];
  assign disk = in_tdata[5:2];
  assign blk  = in_tdata[13:6];
  assign word = in_tdata[77:14];

  // configuration
  logic       enabled_r;
  logic [6:0] entries_r;
  logic       cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    case (cfg_paddr[2])
      REG_ENABLED[0]: cfg_prdata = {31'd0, enabled_r};
      default:        cfg_prdata = {25'd0, entries_r};
    endcase
  end

  logic [NUM_W-1:0] n_act;
  always_comb begin
    if (entries_r < 7'd2) n_act = NUM_W'(2);
    else if (entries_r > 7'(MAX_ENTRIES)) n_act = NUM_W'(MAX_ENTRIES);
    else n_act = NUM_W'(entries_r);
  end

  // tag store
  logic [MAX_ENTRIES-1:0] valid_r;
  logic [3:0]  tdisk_r  [MAX_ENTRIES];
  logic [7:0]  tblk_r   [MAX_ENTRIES];
  logic [31:0] stamp_r  [MAX_ENTRIES];
  logic [31:0] clock_r;

  // parallel hit search and free search
  logic              hit;
  logic [SLOT_W-1:0] hit_idx;
  logic              has_free;
  logic [SLOT_W-1:0] free_idx;
  logic [SLOT_W-1:0] mru_idx;
  always_comb begin
    hit = 1'b0; hit_idx = '0; has_free = 1'b0; free_idx = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (NUM_W'(i) < n_act) begin
        if (valid_r[i] && tdisk_r[i] == disk && tblk_r[i] == blk) begin
          hit = 1'b1; hit_idx = SLOT_W'(i);
        end
        if (!valid_r[i]) begin
          has_free = 1'b1; free_idx = SLOT_W'(i);
        end
      end
    end
  end

  // MRU choice: pairwise compare tree, ties keep the lower index
  logic [31:0]       mru_tv [MAX_ENTRIES];
  logic [SLOT_W-1:0] mru_ti [MAX_ENTRIES];
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      mru_tv[i] = (NUM_W'(i) < n_act) ? stamp_r[i] : '0;
      mru_ti[i] = SLOT_W'(i);
    end
    for (int s = 1; s < MAX_ENTRIES; s = s * 2) begin
      for (int i = 0; i + s < MAX_ENTRIES; i = i + 2 * s) begin
        if (mru_tv[i + s] > mru_tv[i]) begin
          mru_tv[i] = mru_tv[i + s];
          mru_ti[i] = mru_ti[i + s];
        end
      end
    end
  end
  assign mru_idx = mru_ti[0];

  // run state and read streaming
  logic              run_active_r, run_writing_r;
  logic [SLOT_W-1:0] run_slot_r;
  logic [CNT_W-1:0]  run_cnt_r;
  logic              rd_busy_r;
  logic [SLOT_W-1:0] rd_slot_r;
  logic [WORD_W-1:0] rd_ptr_r;
  logic              rd_pend_r;
  logic              rd_plast_r;

  result_t res_r;
  logic    res_v_r;
  logic    res_free;
  assign res_free = !res_v_r || out_tready;
  assign out_tvalid = res_v_r;
  assign out_tdata  = {6'd0, res_r.word, res_r.status};
  assign out_tlast  = res_r.last;

  // a pending RAM read must land in the output register; issue only when
  // the register will be free next cycle or the pending word moves now
  logic issue;
  assign issue = rd_busy_r && (!rd_pend_r || res_free) && (!res_v_r || out_tready);
  assign in_tready = !rd_busy_r && !rd_pend_r && res_free;

  logic acc;
  assign acc = in_tvalid && in_tready;

  // data RAM; a stalled pending word is read again from its own address
  logic               dwe;
  logic [DATA_AW-1:0] dwaddr, draddr;
  logic [63:0]        drdata;
  logic               rd_hold;
  logic [WORD_W-1:0]  rd_addr;
  assign rd_hold = rd_pend_r && !res_free;
  assign rd_addr = rd_hold ? rd_ptr_r - 1'b1 : rd_ptr_r;
  assign draddr  = {rd_slot_r, rd_addr};

  bcm_ram #(.WIDTH(64), .DEPTH(MAX_ENTRIES * BLOCK_WORDS)) u_data (
    .clk(clk), .we(dwe), .waddr(dwaddr), .wdata(word),
    .raddr(draddr), .rdata(drdata)
  );

  // beat processing
  logic              opens;
  logic              wr_now;
  logic [SLOT_W-1:0] wr_slot;
  logic              ins_ok;
  logic [SLOT_W-1:0] ins_slot;
  assign opens   = !run_active_r;
  assign ins_ok  = !hit;
  assign ins_slot = has_free ? free_idx : mru_idx;

  always_comb begin
    wr_now  = run_writing_r;
    wr_slot = run_slot_r;
    if (opens) begin
      if (cmd == CMD_UPDATE) begin
        wr_now = hit; wr_slot = hit_idx;
      end else begin
        wr_now = ins_ok; wr_slot = ins_slot;
      end
    end
  end

  logic beat_data;
  assign beat_data = acc && enabled_r && cmd != CMD_UNUSED && cmd != CMD_LOOKUP;
  assign dwe    = beat_data && wr_now && run_cnt_r < CNT_W'(BLOCK_WORDS);
  assign dwaddr = {wr_slot, run_cnt_r[WORD_W-1:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0; entries_r <= 7'd2;
      valid_r <= '0; clock_r <= '0;
      run_active_r <= 1'b0; run_writing_r <= 1'b0; run_cnt_r <= '0;
      run_slot_r <= '0;
      rd_busy_r <= 1'b0; rd_pend_r <= 1'b0; res_v_r <= 1'b0;
      for (int i = 0; i < MAX_ENTRIES; i++) stamp_r[i] <= '0;
    end else begin
      if (out_tready) res_v_r <= 1'b0;
      // read stream: RAM word lands in the output register
      if (rd_pend_r && res_free) begin
        res_v_r <= 1'b1;
        res_r <= '{status: ST_OK, word: drdata, last: rd_plast_r};
        rd_pend_r <= 1'b0;
      end
      if (issue) begin
        rd_pend_r  <= 1'b1;
        rd_plast_r <= rd_ptr_r == WORD_W'(BLOCK_WORDS - 1);
        rd_ptr_r   <= rd_ptr_r + 1'b1;
        if (rd_ptr_r == WORD_W'(BLOCK_WORDS - 1)) rd_busy_r <= 1'b0;
      end
      if (cfg_wr) begin
        if (cfg_paddr[2] == REG_ENTRIES[0]) entries_r <= cfg_pwdata[6:0];
        else begin
          if (cfg_pwdata[0] && !enabled_r) begin
            valid_r <= '0; clock_r <= '0;
            for (int i = 0; i < MAX_ENTRIES; i++) stamp_r[i] <= '0;
          end
          if (cfg_pwdata[0] != enabled_r) begin
            run_active_r <= 1'b0; run_writing_r <= 1'b0; run_cnt_r <= '0;
          end
          enabled_r <= cfg_pwdata[0];
        end
      end
      if (acc && cmd != CMD_UNUSED) begin
        if (!enabled_r) begin
          run_active_r <= 1'b0; run_writing_r <= 1'b0; run_cnt_r <= '0;
          if (cmd == CMD_LOOKUP || in_tlast) begin
            res_v_r <= 1'b1; res_r <= '{status: ST_OFF, word: '0, last: 1'b1};
          end
        end else if (cmd == CMD_LOOKUP) begin
          run_active_r <= 1'b0; run_writing_r <= 1'b0; run_cnt_r <= '0;
          if (hit) begin
            clock_r <= clock_r + 1'b1;
            stamp_r[hit_idx] <= clock_r + 1'b1;
            rd_busy_r <= 1'b1; rd_slot_r <= hit_idx; rd_ptr_r <= '0;
          end else begin
            res_v_r <= 1'b1; res_r <= '{status: ST_MISS, word: '0, last: 1'b1};
          end
        end else begin
          if (opens && wr_now) begin
            clock_r <= clock_r + 1'b1;
            stamp_r[wr_slot] <= clock_r + 1'b1;
            if (cmd != CMD_UPDATE) begin
              valid_r[wr_slot] <= 1'b1;
              tdisk_r[wr_slot] <= disk;
              tblk_r[wr_slot]  <= blk;
            end
          end
          run_slot_r <= wr_slot;
          if (in_tlast) begin
            run_active_r <= 1'b0; run_writing_r <= 1'b0; run_cnt_r <= '0;
            res_v_r <= 1'b1;
            res_r <= '{status: wr_now ? ST_OK : ST_MISS, word: '0, last: 1'b1};
          end else begin
            run_active_r <= 1'b1; run_writing_r <= wr_now;
            run_cnt_r <= dwe ? run_cnt_r + 1'b1 : (opens ? '0 : run_cnt_r);
          end
        end
      end
    end
  end

`ifndef SYNTHESIS
  // no beat is taken while a lookup stream is in flight
  a_no_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rd_busy_r |-> !in_tready) else $error("beat taken during stream");
  // a held result is not overwritten
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    res_v_r && !out_tready |=> res_v_r) else $error("result lost");
  // data is written only into an active entry slot
  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    dwe |-> NUM_W'(wr_slot) < n_act) else $error("write outside entries");
`endif
endmodule
